// ===== hw/rtl/trial_division_prime_test_assert.svh =====
// Assertion macros shared by the trial division prime test RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TDPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdpt assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdpt assertion failed");

`endif

// ===== hw/rtl/tdpt_pkg.sv =====
// Shared types and constants for the trial division prime test.
// No dependencies; imported by tdpt_rem, trial_division_prime_test and tb.
package tdpt_pkg;

  // Default width of the tested value
  localparam int TDPT_VALUE_WIDTH = 32;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE
  } tdpt_state_t;

  // Status from the remainder unit back to the sequencer
  typedef struct packed {
    logic done;  // one-cycle pulse, remainder is final
    logic zero;  // remainder is zero, valid with done
  } tdpt_rem_status_t;

endpackage

// ===== hw/rtl/trial_division_prime_test.sv =====
// Trial division prime test. Results are registered from the final decision.
// 0, 1, 2 and even values: out_valid in the cycle after start. Odd values: each
// odd divisor takes a bound check plus a bit-serial remainder. One item at a
// time; busy is high until the result. Synchronous active-low reset returns to
// idle with no result pending.
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = TDPT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic                   out_is_prime
);

  tdpt_state_t            state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_prime_r, out_prime_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [VALUE_WIDTH:0]   sq_r, sq_nxt;   // (d-1)^2
  logic [VALUE_WIDTH+1:0] sq_sum;
  logic                   rem_start;
  tdpt_rem_status_t       rem_st;

  // (d+1)^2 = (d-1)^2 + 4d
  assign sq_sum = {1'b0, sq_r} + {d_r, 2'b00};

  tdpt_rem #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (rem_start),
    .dividend_i(n_r),
    .divisor_i (d_r),
    .status_o  (rem_st)
  );

  // Sequencer: screen trivial values, then step odd divisors
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt  = in_value;
          d_nxt  = VALUE_WIDTH'(3);
          sq_nxt = (VALUE_WIDTH+1)'(4);
          priority if (in_value <= VALUE_WIDTH'(1)) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else if (in_value == VALUE_WIDTH'(2)) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b1;
          end else if (!in_value[0]) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r >= {1'b0, n_r}) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rem_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            d_nxt     = d_r + VALUE_WIDTH'(2);
            sq_nxt    = sq_sum[VALUE_WIDTH:0];
            state_nxt = ST_CHECK;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_prime_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_prime_r <= out_prime_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r  <= n_nxt;
    d_r  <= d_nxt;
    sq_r <= sq_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

  `TDPT_ASSERT_IMPL(a_result_when_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `TDPT_ASSERT_NEXT(a_check_exits, clk, rst_n, state_r == ST_CHECK, (state_r == ST_DIVIDE) || (state_r == ST_IDLE))
  `TDPT_ASSERT_NEXT(a_even_fast, clk, rst_n, start && !busy && !in_value[0], out_valid_r)

endmodule

// ===== hw/rtl/tdpt_rem.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg and trial_division_prime_test_assert.svh.
`include "trial_division_prime_test_assert.svh"

module tdpt_rem
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = TDPT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,  // held stable while running
  output tdpt_rem_status_t       status_o
);

  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  logic                   active_r, active_nxt;
  logic                   done_r, done_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] shift_r, shift_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  // One restoring step: bring down the next bit, subtract if it fits
  assign trial = {rem_r, shift_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    rem_nxt    = rem_r;
    if (start_i) begin
      active_nxt = 1'b1;
      cnt_nxt    = CntW'(VALUE_WIDTH);
      shift_nxt  = dividend_i;
      rem_nxt    = '0;
    end else if (active_r) begin
      shift_nxt = {shift_r[VALUE_WIDTH-2:0], 1'b0};
      rem_nxt   = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      cnt_nxt   = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign status_o.done = done_r;
  assign status_o.zero = (rem_r == '0);

  `TDPT_ASSERT_IMPL(a_done_not_active, clk, rst_n, done_r, !active_r)
  `TDPT_ASSERT_NEXT(a_start_runs, clk, rst_n, start_i, active_r && (cnt_r == CntW'(VALUE_WIDTH)))
  `TDPT_ASSERT_NEXT(a_last_bit_done, clk, rst_n, active_r && (cnt_r == CntW'(1)) && !start_i, done_r)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for trial_division_prime_test: sends integers, predicts each verdict
// with a local trial-division routine and compares every result strobe.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.
module tb
  import tdpt_pkg::*;
();

  localparam int W = TDPT_VALUE_WIDTH;
  // slowest item is the largest 32-bit prime; the rest are short
  localparam longint unsigned CYCLE_LIMIT = 12_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [W-1:0] value;
    logic         is_prime;
  } verdict_t;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  logic [W-1:0] in_value;
  logic         out_valid;
  logic         out_is_prime;

  verdict_t        pending_verdicts[$];
  int              mismatch_count;
  int              burst_left;
  longint unsigned cycle_count;

  trial_division_prime_test dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Trial division with the overflow-free bound (d-1) <= (n-1)/(d-1)
  function automatic logic prime_verdict(logic [W-1:0] value);
    longint unsigned n;
    longint unsigned d;
    longint unsigned a;
    n = value;
    if (n <= 1) return 1'b0;
    if (n == 2) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; ; d += 2) begin
      a = d - 1;
      if (a > (n - 1) / a) break;
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one item; idle gaps come between bursts of back-to-back items
  task automatic send_item(logic [W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      start    <= 1'b0;
      in_value <= $urandom;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 5);
    end
    @(negedge clk);
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back('{value: value, is_prime: prime_verdict(value)});
    burst_left--;
  endtask

  // Random value of a random width between lo_w and hi_w bits
  function automatic logic [W-1:0] random_of_width(int lo_w, int hi_w);
    int w;
    w = $urandom_range(lo_w, hi_w);
    return $urandom & ((W'(1) << w) - W'(1));
  endfunction

  // Edges, small primes, prime squares and full-width corners
  task automatic test_directed_values();
    logic [W-1:0] corner_values[$];
    corner_values = '{0, 1, 2, 3, 4, 5, 8, 9, 25, 49, 97, 121, 169, 65521,
                      65537, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE,
                      32'hFFFF_FFFB};
    foreach (corner_values[i]) send_item(corner_values[i]);
  endtask

  // Short values: the bulk of primes and composites, quick to test
  task automatic test_small_random(int count);
    repeat (count) send_item(random_of_width(1, 16));
  endtask

  // Wide values, mostly with a small odd factor and otherwise even, so the block stops early
  task automatic test_wide_composites(int count);
    logic [W-1:0] factor;
    logic [W-1:0] multiple;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item($urandom & ~W'(1));
      end else begin
        factor   = $urandom_range(3, 255) | 1;
        multiple = $urandom_range(1, 32'hFFFF_FFFF / factor);
        send_item(factor * multiple);
      end
    end
  endtask

  // A few mid-size values, where primes mean longer divisor runs
  task automatic test_medium_random(int count);
    repeat (count) send_item(random_of_width(17, 20));
    repeat (2) send_item(random_of_width(24, 24));
  endtask

  // Result checker: every strobe must match the oldest pending verdict
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("tb: unexpected result is_prime=%b", out_is_prime);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_is_prime !== want.is_prime) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("tb: value %0d is_prime expected %b got %b",
                     want.value, want.is_prime, out_is_prime);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    start          = 1'b0;
    in_value       = '0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    cycle_count    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_values();
    test_small_random(40);
    test_wide_composites(30);
    test_medium_random(8);

    @(negedge clk);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_rem.sv
hw/rtl/trial_division_prime_test.sv
bench/tb.sv
